### rtl/core/tvn_pkg.sv
// ----------------------------------------------------------------------------
// tvn_pkg
// Shared types and constants of the tricubic value-noise texel block.
// ----------------------------------------------------------------------------
`default_nettype none

package tvn_pkg;

    // opcodes of an input request
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // mode register codes
    localparam logic [1:0] MODE_RAW   = 2'd0;
    localparam logic [1:0] MODE_NOISE = 2'd1;
    localparam logic [1:0] MODE_ABS   = 2'd2;
    localparam logic [1:0] MODE_VEINS = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_MODE = 2'd0;
    localparam logic [1:0] CFG_STEP = 2'd1;
    localparam logic [1:0] CFG_AMP  = 2'd2;

    localparam logic [1:0]  RST_MODE = MODE_NOISE;
    localparam logic [23:0] RST_STEP = 24'd8192;
    localparam logic [15:0] RST_AMP  = 16'd256;

    // widest axis index carried between front and back
    localparam int AXIS_W = 8;
    localparam int WT_W   = 18;

    typedef logic signed [WT_W-1:0] t_wt;

    typedef struct packed {
        logic              opcode;
        logic [14:0]       lattice_index;
        logic signed [15:0] lattice_value;
        logic [9:0]        texel_x;
        logic [9:0]        texel_y;
        logic [9:0]        texel_z;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] filtered_value;
        logic [7:0]         texel_byte;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  mode;
        logic [23:0] step;
        logic [15:0] amp;
    } t_cfg;

    // classified command, front to back
    typedef struct packed {
        logic              is_sample;
        logic [14:0]       widx;
        logic [15:0]       wval;
        logic [AXIS_W-1:0] base_x;
        logic [AXIS_W-1:0] base_y;
        logic [AXIS_W-1:0] base_z;
        t_wt [11:0]        w;      // axis*4 + tap
    } t_cmd;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_CALC,
        FS_PUSH
    } t_fstate;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_ISSUE,
        BS_DRAIN,
        BS_POST1,
        BS_POST2,
        BS_POST3,
        BS_OUT
    } t_bstate;

    typedef enum logic [1:0] {
        SRC_RAM,
        SRC_Y,
        SRC_Z
    } t_src;

    typedef enum logic [1:0] {
        WS_X,
        WS_Y,
        WS_Z,
        WS_UNIT
    } t_wsel;

    typedef enum logic [1:0] {
        DST_Y,
        DST_Z,
        DST_R
    } t_dst;

    typedef struct packed {
        logic       valid;
        t_src       src;
        t_wsel      wsel;
        logic [1:0] tap;
        t_dst       dst;
        logic [1:0] didx;
        logic       last;
    } t_uop;

endpackage

`default_nettype wire

### rtl/core/tvn_ram.sv
// ----------------------------------------------------------------------------
// tvn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tvn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/tvn_front.sv
// ----------------------------------------------------------------------------
// tvn_front
// Accepts requests, splits sample coordinates and computes kernel weights.
// ----------------------------------------------------------------------------
`default_nettype none

module tvn_front #(
    parameter int TEXEL_BITS = 10
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tvn_pkg::t_cfg     i_cfg,
    input  wire logic              i_push,
    input  wire tvn_pkg::t_in_item i_item,
    output logic                   o_full,
    input  wire logic              i_q_full,
    output logic                   o_q_push,
    output tvn_pkg::t_cmd          o_q_data
);
    import tvn_pkg::*;

    localparam logic [9:0] TMASK = 10'((1 << TEXEL_BITS) - 1);

    t_fstate r_state, n_state;
    t_in_item r_item;
    logic [1:0]  r_axis;
    logic [3:0]  r_st;
    logic [57:0] r_prod;
    logic [15:0] r_t;
    logic [16:0] r_s;
    logic [32:0] r_ts, r_tt, r_ss;
    t_wt [11:0]  r_w;
    logic [AXIS_W-1:0] r_base [3];

    logic        accept, calc_done;
    logic [9:0]  texel;
    logic [33:0] mul_a;
    logic [23:0] mul_b;
    logic [36:0] coord;
    logic [57:0] qsum;
    logic [16:0] q;
    logic [3:0]  widx;

    always_comb begin
        unique case (r_axis)
            2'd0:    texel = r_item.texel_x & TMASK;
            2'd1:    texel = r_item.texel_y & TMASK;
            default: texel = r_item.texel_z & TMASK;
        endcase
    end

    // operand selection of the shared multiplier
    always_comb begin
        unique case (r_st)
            4'd0: begin mul_a = {24'b0, texel}; mul_b = i_cfg.step;                    end
            4'd2: begin mul_a = {18'b0, r_t};   mul_b = {7'b0, r_s};                   end
            4'd3: begin mul_a = {18'b0, r_t};   mul_b = {8'b0, r_t};                   end
            4'd4: begin mul_a = {17'b0, r_s};   mul_b = {7'b0, r_s};                   end
            4'd5: begin mul_a = {1'b0, r_ts};   mul_b = {7'b0, r_s};                   end
            4'd6: begin mul_a = {1'b0, r_ts};   mul_b = {8'b0, r_t};                   end
            4'd7: begin mul_a = {1'b0, r_tt};   mul_b = 24'(18'h10000 + {1'b0, r_s});  end
            4'd8: begin mul_a = {1'b0, r_ss};   mul_b = 24'(18'h10000 + {2'b0, r_t});  end
            default: begin mul_a = '0;          mul_b = '0;                            end
        endcase
    end

    assign coord = {1'b0, r_prod[35:0]} - 37'd32768;
    assign qsum  = r_prod + 58'h8000_0000;
    assign q     = qsum[48:32];
    assign widx  = {r_axis, 2'b00};

    assign accept    = i_push && (r_state == FS_IDLE);
    assign calc_done = (r_st == 4'd9) && (r_axis == 2'd2);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FS_IDLE: begin
                if (accept) begin
                    n_state = (i_item.opcode == OP_SAMPLE) ? FS_CALC : FS_PUSH;
                end
            end
            FS_CALC: begin
                if (calc_done) begin
                    n_state = FS_PUSH;
                end
            end
            FS_PUSH: begin
                if (!i_q_full) begin
                    n_state = FS_IDLE;
                end
            end
            default: n_state = FS_IDLE;
        endcase
    end

    always_comb begin
        o_full   = (r_state != FS_IDLE);
        o_q_push = (r_state == FS_PUSH) && !i_q_full;
        o_q_data.is_sample = (r_item.opcode == OP_SAMPLE);
        o_q_data.widx      = r_item.lattice_index;
        o_q_data.wval      = r_item.lattice_value;
        o_q_data.base_x    = r_base[0];
        o_q_data.base_y    = r_base[1];
        o_q_data.base_z    = r_base[2];
        o_q_data.w         = r_w;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= {24'b0, mul_a} * {34'b0, mul_b};
        if (accept) begin
            r_item <= i_item;
            r_axis <= 2'd0;
            r_st   <= 4'd0;
        end else if (r_state == FS_CALC) begin
            unique case (r_st)
                4'd1: begin
                    r_t <= coord[15:0];
                    r_s <= 17'h10000 - {1'b0, coord[15:0]};
                    if (i_cfg.mode == MODE_RAW) begin
                        r_base[r_axis] <= coord[36] ? '0 : coord[16 +: AXIS_W];
                    end else begin
                        r_base[r_axis] <= coord[16 +: AXIS_W] - AXIS_W'(1);
                    end
                end
                4'd3: r_ts <= r_prod[32:0];
                4'd4: r_tt <= r_prod[32:0];
                4'd5: r_ss <= r_prod[32:0];
                4'd6: r_w[widx]        <= t_wt'(-$signed({1'b0, q}));
                4'd7: r_w[widx + 4'd3] <= t_wt'(-$signed({1'b0, q}));
                4'd8: r_w[widx + 4'd1] <= t_wt'(18'sd65536 - $signed({1'b0, q}));
                4'd9: r_w[widx + 4'd2] <= t_wt'(18'sd65536 - $signed({1'b0, q}));
                default: ;
            endcase
            if (r_st == 4'd9) begin
                r_st   <= 4'd0;
                r_axis <= r_axis + 2'd1;
            end else begin
                r_st <= r_st + 4'd1;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/tvn_queue.sv
// ----------------------------------------------------------------------------
// tvn_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module tvn_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire tvn_pkg::t_cmd i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_empty,
    output tvn_pkg::t_cmd      o_data
);
    import tvn_pkg::*;

    t_cmd       r_ent [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

### rtl/core/tvn_back.sv
// ----------------------------------------------------------------------------
// tvn_back
// Lattice store, shared multiply-accumulate filter and output mapping.
// ----------------------------------------------------------------------------
`default_nettype none

module tvn_back #(
    parameter int LATTICE_X_BITS = 5,
    parameter int LATTICE_Y_BITS = 5,
    parameter int LATTICE_Z_BITS = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire tvn_pkg::t_cfg i_cfg,
    input  wire logic          i_cmd_empty,
    input  wire tvn_pkg::t_cmd i_cmd,
    output logic               o_cmd_pop,
    input  wire logic          i_out_pop,
    output logic               o_out_empty,
    output tvn_pkg::t_out_item o_out
);
    import tvn_pkg::*;

    localparam int AW    = LATTICE_X_BITS + LATTICE_Y_BITS + LATTICE_Z_BITS;
    localparam int DEPTH = 1 << AW;

    t_bstate r_state, n_state;
    t_cmd    r_cmd;
    logic [1:0] r_k, r_i;
    logic [2:0] r_j;
    logic       r_zp, r_raw;
    t_uop       r_s1, r_s2, uop;
    logic signed [35:0] r_prod;
    logic signed [37:0] r_acc;
    logic signed [17:0] r_y [4];
    logic signed [17:0] r_z [4];
    logic signed [17:0] r_res;
    logic [14:0] r_n;
    logic [15:0] r_fv;
    logic [30:0] r_na;
    logic [38:0] r_nb;
    logic        r_out_valid;
    t_out_item   r_out;

    logic        final_uop, stall, issue, start, ram_we, ram_re, load_out;
    logic [AXIS_W-1:0] ax, ay, az;
    logic [AW-1:0] raddr;
    logic [15:0] rdata;
    logic signed [17:0] opv;
    t_wt         opw;
    logic signed [37:0] acc_sum, rnd;
    logic signed [17:0] rc, absr;
    logic signed [18:0] nm;
    logic [14:0] n_clamped;
    logic [16:0] byte_hi;

    // current micro-op from the nested counters
    always_comb begin
        uop       = '0;
        uop.valid = 1'b1;
        uop.tap   = r_i;
        uop.last  = (r_i == 2'd3);
        final_uop = 1'b0;
        if (r_raw) begin
            uop.src   = SRC_RAM;
            uop.wsel  = WS_UNIT;
            uop.dst   = DST_R;
            uop.last  = 1'b1;
            final_uop = 1'b1;
        end else if (r_zp) begin
            uop.src   = SRC_Z;
            uop.wsel  = WS_Z;
            uop.dst   = DST_R;
            final_uop = (r_i == 2'd3);
        end else if (r_j == 3'd4) begin
            uop.src  = SRC_Y;
            uop.wsel = WS_Y;
            uop.dst  = DST_Z;
            uop.didx = r_k;
        end else begin
            uop.src  = SRC_RAM;
            uop.wsel = WS_X;
            uop.dst  = DST_Y;
            uop.didx = r_j[1:0];
        end
    end

    assign ax = r_cmd.base_x + AXIS_W'(r_i);
    assign ay = r_cmd.base_y + AXIS_W'(r_j[1:0]);
    assign az = r_cmd.base_z + AXIS_W'(r_k);
    assign raddr = {az[LATTICE_Z_BITS-1:0], ay[LATTICE_Y_BITS-1:0],
                    ax[LATTICE_X_BITS-1:0]};

    // a pass over stored results waits until the pipe has written them
    assign stall = (uop.src != SRC_RAM) && (r_s1.valid || r_s2.valid);

    tvn_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(i_cmd.widx)),
        .i_wdata (i_cmd.wval),
        .i_re    (ram_re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE: begin
                if (!i_cmd_empty && i_cmd.is_sample) begin
                    n_state = BS_ISSUE;
                end
            end
            BS_ISSUE: begin
                if (!stall && final_uop) begin
                    n_state = BS_DRAIN;
                end
            end
            BS_DRAIN: begin
                if (!r_s1.valid && !r_s2.valid) begin
                    n_state = BS_POST1;
                end
            end
            BS_POST1: n_state = BS_POST2;
            BS_POST2: n_state = BS_POST3;
            BS_POST3: n_state = BS_OUT;
            BS_OUT: begin
                if (!r_out_valid) begin
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop = (r_state == BS_IDLE) && !i_cmd_empty;
        start     = o_cmd_pop && i_cmd.is_sample;
        ram_we    = o_cmd_pop && !i_cmd.is_sample;
        issue     = (r_state == BS_ISSUE) && !stall;
        ram_re    = issue && (uop.src == SRC_RAM);
        load_out  = (r_state == BS_OUT) && !r_out_valid;
    end

    // stage 1 operands
    always_comb begin
        unique case (r_s1.src)
            SRC_Y:   opv = r_y[r_s1.tap];
            SRC_Z:   opv = r_z[r_s1.tap];
            default: opv = 18'(signed'(rdata));
        endcase
        unique case (r_s1.wsel)
            WS_X:    opw = r_cmd.w[{2'd0, r_s1.tap}];
            WS_Y:    opw = r_cmd.w[{2'd1, r_s1.tap}];
            WS_Z:    opw = r_cmd.w[{2'd2, r_s1.tap}];
            default: opw = 18'sd65536;
        endcase
    end

    assign acc_sum = ((r_s2.tap == 2'd0) ? 38'sd0 : r_acc) + 38'(r_prod);
    assign rnd     = acc_sum + 38'sd32768;

    // mode mapping
    always_comb begin
        if (r_res > 18'sd16384) begin
            rc = 18'sd16384;
        end else if (r_res < -18'sd16384) begin
            rc = -18'sd16384;
        end else begin
            rc = r_res;
        end
        absr = (rc < 0) ? -rc : rc;
        unique case (i_cfg.mode)
            MODE_RAW: begin
                nm = 19'(r_res) + 19'sd16384;
                nm = (nm < 0) ? 19'sd0 : (nm >>> 1);
            end
            MODE_NOISE: nm = (19'(rc) + 19'sd16384) >>> 1;
            MODE_ABS:   nm = 19'(absr);
            default:    nm = 19'sd16384 - (19'(absr) <<< 1);
        endcase
        if (nm < 0) begin
            n_clamped = 15'd0;
        end else if (nm > 19'sd16384) begin
            n_clamped = 15'd16384;
        end else begin
            n_clamped = nm[14:0];
        end
    end

    assign byte_hi = r_nb[38:22];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_s1.valid  <= 1'b0;
            r_s2.valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_s1    <= issue ? uop : '0;
            r_s2    <= r_s1;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_cmd <= i_cmd;
            r_k   <= 2'd0;
            r_j   <= 3'd0;
            r_i   <= 2'd0;
            r_zp  <= 1'b0;
            r_raw <= (i_cfg.mode == MODE_RAW);
        end else if (issue && !final_uop) begin
            r_i <= r_i + 2'd1;
            if (r_i == 2'd3) begin
                if (r_j == 3'd4) begin
                    r_j <= 3'd0;
                    if (r_k == 2'd3) begin
                        r_zp <= 1'b1;
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end else begin
                    r_j <= r_j + 3'd1;
                end
            end
        end

        r_prod <= opv * opw;
        if (r_s2.valid) begin
            r_acc <= acc_sum;
            if (r_s2.last) begin
                unique case (r_s2.dst)
                    DST_Y:   r_y[r_s2.didx] <= rnd[33:16];
                    DST_Z:   r_z[r_s2.didx] <= rnd[33:16];
                    default: r_res          <= rnd[33:16];
                endcase
            end
        end

        if (r_state == BS_POST1) begin
            r_n  <= n_clamped;
            r_fv <= (i_cfg.mode == MODE_RAW) ? r_res[15:0] : rc[15:0];
        end
        if (r_state == BS_POST2) begin
            r_na <= {16'b0, r_n} * {15'b0, i_cfg.amp};
        end
        if (r_state == BS_POST3) begin
            r_nb <= {r_na, 8'b0} - {8'b0, r_na};
        end
        if (load_out) begin
            r_out.filtered_value <= r_fv;
            r_out.texel_byte     <= (byte_hi > 17'd255) ? 8'hff : byte_hi[7:0];
        end
    end

    assign o_out_empty = !r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

### rtl/core/tricubic_value_noise_texel.sv
// ----------------------------------------------------------------------------
// tricubic_value_noise_texel
// Tricubic value-noise texel generator over a wrapped 3D lattice.
// ----------------------------------------------------------------------------
// usage
//   input queue side: drive i_in and raise push; the request is taken on a
//   clock edge with push high and full low. a write request (opcode 0) stores
//   one lattice entry; a sample request (opcode 1) yields exactly one result.
//   result queue side: while empty is low o_out holds the oldest result, and
//   it is taken on an edge with pop high. pop may stall as long as needed;
//   work keeps going and only the final hand-off of the next result waits.
//   configuration: i_cfg_valid/o_cfg_ready write mode (0), step (1) and
//   amplitude (2); other indexes are ignored. write only while idle.
//   processing: a write passes through the front and the command queue into
//   the lattice. a sample takes three axes of ten steps on one multiplier in
//   the front and 84 multiply-accumulate operations through one unit in the
//   back, plus pipe drains and the mapping states POST1 to POST3 and OUT.
//   raw mode needs one lattice read.
//   overlap: front and back overlap through a two-entry command queue, so the
//   front can take a new sample while the back still works on the last one.
//   reset: synchronous, active low; queues empty, registers to defaults. the
//   lattice is not cleared: an entry reads as garbage until written.
// ----------------------------------------------------------------------------
`default_nettype none

module tricubic_value_noise_texel #(
    parameter int LATTICE_X_BITS = 5,
    parameter int LATTICE_Y_BITS = 5,
    parameter int LATTICE_Z_BITS = 5,
    parameter int TEXEL_BITS     = 10
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // request side
    input  wire logic               push,
    input  wire tvn_pkg::t_in_item  i_in,
    output logic                    full,
    // result side
    input  wire logic               pop,
    output logic                    empty,
    output tvn_pkg::t_out_item      o_out,
    // configuration writes
    input  wire logic               i_cfg_valid,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [23:0]        i_cfg_data,
    output logic                    o_cfg_ready
);
    import tvn_pkg::*;

    t_cfg r_cfg;
    t_cmd q_in, q_out;
    logic q_push, q_full, q_pop, q_empty;

    // config registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode <= RST_MODE;
            r_cfg.step <= RST_STEP;
            r_cfg.amp  <= RST_AMP;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MODE: r_cfg.mode <= i_cfg_data[1:0];
                CFG_STEP: r_cfg.step <= i_cfg_data;
                CFG_AMP:  r_cfg.amp  <= i_cfg_data[15:0];
                default:  ;
            endcase
        end
    end

    // front: takes requests, splits coordinates, builds kernel weights
    tvn_front #(
        .TEXEL_BITS (TEXEL_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_push   (push),
        .i_item   (i_in),
        .o_full   (full),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_data (q_in)
    );

    // decoupling queue of classified commands
    tvn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    // back: lattice store, filter passes, mode and gain, result register
    tvn_back #(
        .LATTICE_X_BITS (LATTICE_X_BITS),
        .LATTICE_Y_BITS (LATTICE_Y_BITS),
        .LATTICE_Z_BITS (LATTICE_Z_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_empty (q_empty),
        .i_cmd       (q_out),
        .o_cmd_pop   (q_pop),
        .i_out_pop   (pop),
        .o_out_empty (empty),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

### rtl/core/tvn_checker.sv
// ----------------------------------------------------------------------------
// tvn_checker
// Port-level checks of the texel block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tvn_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               push,
    input wire logic               full,
    input wire logic               pop,
    input wire logic               empty,
    input wire tvn_pkg::t_out_item o_out
);

    // no result survives a reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result visible after reset");

    // a taken request keeps the front busy on the next cycle
    a_push_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !full |=> full)
        else $error("front not busy after a request");

    // a waiting result is not withdrawn
    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty)
        else $error("result dropped without pop");

    // a waiting result holds its value
    a_result_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> $stable(o_out))
        else $error("result changed while stalled");

endmodule

bind tricubic_value_noise_texel tvn_checker u_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .push    (push),
    .full    (full),
    .pop     (pop),
    .empty   (empty),
    .o_out   (o_out)
);

`default_nettype wire
